[hw/rtl/lfce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfce_pkg: shared types and constants of the log line fault code extractor.
// Holds the parse phase encoding, the result record and the marker text.
// ----------------------------------------------------------------------------
package lfce_pkg;

	// Marker text is "NVRM: Xid (" and is eleven characters long.
	localparam int unsigned MARKER_LEN = 11;
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] MARKER_DONE = POS_W'(MARKER_LEN);

	localparam int unsigned CODE_W = 32;

	// Characters of interest.
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_PAREN = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Parse phase, one-hot.
	typedef enum logic [5:0] {
		PH_MARKER = 6'b000001,
		PH_CLOSE  = 6'b000010,
		PH_SKIP   = 6'b000100,
		PH_DIGITS = 6'b001000,
		PH_OK     = 6'b010000,
		PH_FAIL   = 6'b100000
	} phase_t;

	// One result of a finished line.
	typedef struct packed {
		logic              found;
		logic [CODE_W-1:0] code;
	} res_t;

	// Expected marker character at a given match position.
	function automatic logic [7:0] marker_char(input logic [POS_W-1:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h4E; // N
			4'd1:    ch = 8'h56; // V
			4'd2:    ch = 8'h52; // R
			4'd3:    ch = 8'h4D; // M
			4'd4:    ch = 8'h3A; // :
			4'd5:    ch = 8'h20; // space
			4'd6:    ch = 8'h58; // X
			4'd7:    ch = 8'h69; // i
			4'd8:    ch = 8'h64; // d
			4'd9:    ch = 8'h20; // space
			4'd10:   ch = 8'h28; // (
			default: ch = 8'h4E;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/log_line_fault_code_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_line_fault_code_extractor: pulls the fault code out of a log line.
//
// Characters arrive on the input channel (char_byte, end_of_line) with
// in_valid and in_stall, one transfer per character. The block looks for
// the marker text, then for "):", skips blanks and reads a decimal code.
// Exactly one result leaves on the output channel (found, fault_code) with
// out_valid and out_stall for each line, after its last character.
// Throughput is one character per cycle while in_stall is low. A character
// is registered, then the parse state updates as it leaves the input
// register; a line's result passes the input register, then the result register.
// When the receiver stalls, the result register holds its value, and the
// input keeps flowing until a further line end reaches the input register;
// then in_stall rises until the waiting result is taken.
// Reset clears the parse state and empties both registers, so the block
// starts at the beginning of a line and shows no result.
// ----------------------------------------------------------------------------
module log_line_fault_code_extractor
	import lfce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        char_byte,
	input  wire logic              end_of_line,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   found,
	output logic [CODE_W-1:0]      fault_code
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;
	logic       in_take;
	logic       advance;
	res_t       res;

	// A stage-one character moves on unless it ends a line and the result
	// register is still holding an untaken result.
	assign advance  = valid_s1 && (!eol_s1 || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_byte;
			eol_s1  <= end_of_line;
		end
	end

	lfce_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (char_s1),
		.last   (eol_s1),
		.res    (res)
	);

	lfce_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && eol_s1),
		.res        (res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.found      (found),
		.fault_code (fault_code)
	);

endmodule
`default_nettype wire

[hw/rtl/lfce_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfce_parser: per-line parse state and its single-character update.
// Consumes one character per step and returns the result on the last one.
// ----------------------------------------------------------------------------
module lfce_parser
	import lfce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  ch,
	input  wire logic        last,
	output res_t             res
);

	phase_t              phase_q, phase_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic                paren_q, paren_n;
	logic [CODE_W-1:0]   acc_q, acc_n;
	logic                ovf_q, ovf_n;
	logic                seen_q, seen_n;

	logic                is_digit, is_blank;
	logic [CODE_W+3:0]   acc_wide;
	logic                valid_now, valid_next;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);

	// Accumulator times ten plus the new digit, with the carry bits kept.
	assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {28'd0, ch[3:0] - CH_ZERO[3:0]};

	assign valid_now = seen_q && !ovf_q && (acc_q != '0);

	// Next parse state for the current character.
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		paren_n = paren_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		seen_n  = seen_q;
		case (phase_q)
			PH_MARKER: begin
				if (ch == marker_char(pos_q)) begin
					pos_n = pos_q + 1'b1;
				end else begin
					pos_n = (ch == CH_N) ? POS_W'(1) : '0;
				end
				if (pos_n == MARKER_DONE) begin
					phase_n = PH_CLOSE;
					pos_n   = '0;
					paren_n = 1'b0;
				end
			end
			PH_CLOSE: begin
				if (paren_q && (ch == CH_COLON)) begin
					phase_n = PH_SKIP;
					paren_n = 1'b0;
				end else begin
					paren_n = (ch == CH_PAREN);
				end
			end
			PH_SKIP: begin
				if (is_digit) begin
					acc_n   = acc_wide[CODE_W-1:0];
					ovf_n   = ovf_q | (|acc_wide[CODE_W+3:CODE_W]);
					seen_n  = 1'b1;
					phase_n = PH_DIGITS;
				end else if (!is_blank) begin
					phase_n = PH_FAIL;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					acc_n  = acc_wide[CODE_W-1:0];
					ovf_n  = ovf_q | (|acc_wide[CODE_W+3:CODE_W]);
					seen_n = 1'b1;
				end else if ((ch == CH_COMMA) || is_blank) begin
					phase_n = valid_now ? PH_OK : PH_FAIL;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
	end

	// Result of the line as it stands after this character.
	assign valid_next = seen_n && !ovf_n && (acc_n != '0);
	always_comb begin
		res.found = (phase_n == PH_OK) || ((phase_n == PH_DIGITS) && valid_next);
		res.code  = res.found ? acc_n : '0;
	end

	// State registers; the last character of a line clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARKER;
			pos_q   <= '0;
			paren_q <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_MARKER;
				pos_q   <= '0;
				paren_q <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				paren_q <= paren_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/lfce_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfce_out_reg: result register of the extractor.
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lfce_out_reg
	import lfce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire res_t              res,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic                   found,
	output logic [CODE_W-1:0]      fault_code
);

	logic valid_q;
	res_t data_q;

	// Valid flag: set on load, cleared once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload is only written when a new result is loaded.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign found      = data_q.found;
	assign fault_code = data_q.code;

endmodule
`default_nettype wire

[hw/rtl/lfce_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfce_checker: port-level checks of the fault code extractor.
// Watches the two channels and the result fields over time.
// ----------------------------------------------------------------------------
module lfce_checker
	import lfce_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              found,
	input wire logic [CODE_W-1:0] fault_code
);

	// A stalled result stays and keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(fault_code))
		else $error("result changed while stalled");

	// The input only stalls behind a result that the receiver holds back.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled without a held result");

	// A failed line reports a zero code.
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> fault_code == '0)
		else $error("nonzero code without found");

	// A found code is never zero.
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> fault_code != '0)
		else $error("zero code reported as found");

endmodule

bind log_line_fault_code_extractor lfce_checker u_lfce_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.found      (found),
	.fault_code (fault_code)
);
`default_nettype wire

[tb/log_line_fault_code_extractor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_line_fault_code_extractor_test: self-checking bench for the extractor.
// Log lines are sent one character per transfer, first from a table of
// hand-picked lines and then as random lines. Most random lines carry the
// marker and a code, and the rest are noise or broken lines. A line parser
// in the bench predicts the result of every line. The sender idles in bursts
// and the receiver stalls on its own pattern, and each result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module log_line_fault_code_extractor_test
	import lfce_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 400000;
	// Random characters; the directed table adds 383 more.
	localparam int unsigned RANDOM_CHARS = 1430;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned DIR_ROWS = 19;

	// Marker text, first character in the top byte.
	localparam logic [8*MARKER_LEN-1:0] XID_TEXT = "NVRM: Xid (";
	localparam string XID_STR = "NVRM: Xid (";

	// Directed rows that are checked by the line parser, not by a typed value.
	localparam logic [33:0] BY_PARSER = '0;

	typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_RARE} stall_pat_t;
	typedef enum {LK_NOISE, LK_BROKEN_MARKER, LK_NO_CLOSE, LK_NO_DIGITS, LK_GOOD} line_kind_t;
	typedef enum {TM_EOL, TM_COMMA, TM_SPACE, TM_TAB, TM_BAD} term_kind_t;
	typedef enum {NV_SMALL, NV_FULL, NV_NEAR_MAX, NV_ZERO, NV_HUGE} num_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        char_byte = 8'h00;
	logic              end_of_line = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [CODE_W-1:0] fault_code;

	// Parser state of the bench.
	phase_t            ps_phase = PH_MARKER;
	logic [POS_W-1:0]  ps_pos = '0;
	bit                ps_paren = 1'b0;
	logic [CODE_W-1:0] ps_acc = '0;
	bit                ps_ovf = 1'b0;
	bit                ps_digit = 1'b0;

	res_t              pending_results[$];
	logic [7:0]        line_buf[$];
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;
	int unsigned       lines_sent = 0;
	int unsigned       chars_sent = 0;
	int unsigned       results_seen = 0;
	int unsigned       codes_seen = 0;
	int unsigned       burst_left = 0;
	bit                no_gaps = 1'b0;
	logic [7:0]        stall_tick = '0;
	stall_pat_t        stall_mode = STALL_NONE;

	// Directed lines. A typed check is {1, found, code}.
	string       dir_text[DIR_ROWS];
	logic [33:0] dir_check[DIR_ROWS];

	log_line_fault_code_extractor u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.fault_code  (fault_code)
	);

	always #5 clk = ~clk;

	// A code counts only if digits were read, it fits in 32 bits and it is not zero.
	function automatic bit code_usable();
		return ps_digit && !ps_ovf && (ps_acc != '0);
	endfunction

	function automatic void accumulate_digit(input logic [7:0] ch);
		logic [63:0] next_acc;
		next_acc = {32'b0, ps_acc} * 64'd10 + {56'b0, ch - CH_ZERO};
		ps_digit = 1'b1;
		if (next_acc > 64'hFFFF_FFFF)
			ps_ovf = 1'b1;
		ps_acc = next_acc[31:0];
	endfunction

	// Advances the line parser by one character; returns 1 with the line
	// result on the last character of a line.
	function automatic bit parse_char(input logic [7:0] ch, input logic last, output res_t res);
		bit is_digit;
		bit is_blank;
		bit ok;
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
		res = '0;
		case (ps_phase)
			PH_MARKER: begin
				if (ch == XID_TEXT[8*(MARKER_LEN-1-ps_pos) +: 8])
					ps_pos = ps_pos + 1'b1;
				else
					ps_pos = (ch == CH_N) ? POS_W'(1) : '0;
				if (ps_pos == MARKER_DONE) begin
					ps_phase = PH_CLOSE;
					ps_pos = '0;
					ps_paren = 1'b0;
				end
			end
			PH_CLOSE: begin
				if (ps_paren && ch == CH_COLON) begin
					ps_phase = PH_SKIP;
					ps_paren = 1'b0;
				end else begin
					ps_paren = (ch == CH_PAREN);
				end
			end
			PH_SKIP: begin
				if (is_digit) begin
					accumulate_digit(ch);
					ps_phase = PH_DIGITS;
				end else if (!is_blank) begin
					ps_phase = PH_FAIL;
				end
			end
			PH_DIGITS: begin
				if (is_digit)
					accumulate_digit(ch);
				else if (ch == CH_COMMA || is_blank)
					ps_phase = code_usable() ? PH_OK : PH_FAIL;
				else
					ps_phase = PH_FAIL;
			end
			default: ;
		endcase
		if (!last)
			return 1'b0;
		ok = (ps_phase == PH_OK) || (ps_phase == PH_DIGITS && code_usable());
		res.found = ok;
		res.code = ok ? ps_acc : '0;
		ps_phase = PH_MARKER;
		ps_pos = '0;
		ps_paren = 1'b0;
		ps_acc = '0;
		ps_ovf = 1'b0;
		ps_digit = 1'b0;
		return 1'b1;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic add_noise(input int unsigned n);
		repeat (n)
			line_buf.push_back(8'($urandom));
	endtask

	// Sends line_buf as one line; the sender idles between bursts unless the
	// line is sent back to back. A typed check replaces the parser's result.
	task automatic send_line(input logic [33:0] check);
		res_t predicted;
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < line_buf.size(); i++) begin
			if (!no_gaps && burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			if (burst_left != 0)
				burst_left--;
			in_valid <= 1'b1;
			char_byte <= line_buf[i];
			end_of_line <= (i == line_buf.size() - 1);
			do @(posedge clk); while (in_stall);
			chars_sent++;
			if (parse_char(line_buf[i], i == line_buf.size() - 1, predicted))
				pending_results.push_back(check[33] ? res_t'(check[32:0]) : predicted);
		end
		lines_sent++;
	endtask

	// Builds one random line: mostly marker, close, blanks and a code with
	// random content around it, sometimes broken or plain noise.
	task automatic build_random_line();
		line_kind_t kind;
		term_kind_t term;
		num_kind_t  nkind;
		longint unsigned value;
		line_buf.delete();
		add_noise($urandom_range(0, 4));
		case ($urandom_range(0, 9))
			0:       kind = LK_NOISE;
			1:       kind = LK_BROKEN_MARKER;
			2:       kind = LK_NO_CLOSE;
			3:       kind = LK_NO_DIGITS;
			default: kind = LK_GOOD;
		endcase
		if (kind == LK_NOISE) begin
			add_noise($urandom_range(1, 20));
		end else begin
			if (kind == LK_BROKEN_MARKER) begin
				add_text(XID_STR.substr(0, $urandom_range(0, MARKER_LEN - 2)));
				add_noise($urandom_range(0, 2));
			end
			add_text(XID_STR);
			// Text inside the brackets, with stray parens and colons.
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 3))
					0:       line_buf.push_back(CH_PAREN);
					1:       line_buf.push_back(CH_COLON);
					2:       line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
					default: line_buf.push_back(8'($urandom));
				endcase
			end
			if (kind != LK_NO_CLOSE)
				add_text("):");
			repeat ($urandom_range(0, 3))
				line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			if (kind != LK_NO_DIGITS) begin
				nkind = num_kind_t'($urandom_range(0, 4));
				case (nkind)
					NV_SMALL:    value = $urandom_range(1, 999);
					NV_FULL:     value = $urandom;
					NV_NEAR_MAX: value = 64'd4294967290 + $urandom_range(0, 9);
					NV_ZERO:     value = 0;
					default:     value = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF;
				endcase
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
				add_text($sformatf("%0d", value));
			end
			term = term_kind_t'($urandom_range(0, 4));
			case (term)
				TM_COMMA: line_buf.push_back(CH_COMMA);
				TM_SPACE: line_buf.push_back(CH_SPACE);
				TM_TAB:   line_buf.push_back(CH_TAB);
				TM_BAD:   line_buf.push_back(8'($urandom));
				default:  ;
			endcase
			if (term != TM_EOL)
				add_noise($urandom_range(0, 6));
		end
		if (line_buf.size() == 0)
			add_noise(1);
	endtask

	// Receiver stall pattern, changed whenever the low six bits of stall_tick are zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick[5:0] == '0)
			stall_mode <= stall_pat_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
			STALL_LONG: out_stall <= (stall_tick[3:0] < 4'd11);
			default:    out_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Compare each result transfer with the oldest predicted line result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (found)
				codes_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("ERROR: unexpected result found=%0b code=%0d", found, fault_code);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found || fault_code !== want.code) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("ERROR: line result expected found=%0b code=%0d, got found=%0b code=%0d",
							want.found, want.code, found, fault_code);
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned random_start;
		dir_text = '{
			"NVRM: Xid (PCI:0000:01:00): 79, pid=1",
			"NVRM: Xid (0): 4294967295",
			"NVRM: Xid (0): 4294967296,",
			"NVRM: Xid (0): 0,",
			"NVRM: Xid (0): 0007\t",
			"kernel: no marker here",
			"NVRM: Xid (0) 13",
			"NVRM: Xid (0):   \t",
			"NVRM: Xid (0): 13x",
			"NNVRM: Xid (0): 31 ",
			"NVRM: XNVRM: Xid (a)b): 45,9",
			"NVRM: Xid (0):  ))::",
			"NVRM: Xid (0): 12, NVRM: Xid (0): 99",
			"NVRM: Xid (0): x12",
			"\377NVRM: Xid (\200): 8",
			"NVRM: Xid (",
			"N",
			"NVRM: Xid (0):5",
			"NVRM: Xid (0)::): 6"
		};
		dir_check = '{
			{1'b1, 1'b1, 32'd79},
			{1'b1, 1'b1, 32'hFFFF_FFFF},
			{1'b1, 1'b0, 32'd0},
			{1'b1, 1'b0, 32'd0},
			{1'b1, 1'b1, 32'd7},
			{1'b1, 1'b0, 32'd0},
			{1'b1, 1'b0, 32'd0},
			{1'b1, 1'b0, 32'd0},
			{1'b1, 1'b0, 32'd0},
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER,
			BY_PARSER
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines from the table.
		for (int r = 0; r < DIR_ROWS; r++) begin
			line_buf.delete();
			add_text(dir_text[r]);
			send_line(dir_check[r]);
		end

		// Random lines.
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_CHARS) begin
			build_random_line();
			send_line(BY_PARSER);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d lines (%0d characters); %0d line results checked, %0d with a code.",
			lines_sent, chars_sent, results_seen, codes_seen);
		$display("Mismatches: %0d.", fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
